>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the converter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Check an expression at every clock edge out of reset.
`define BDA_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
// Check a consequence in the same cycle.
`define BDA_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Check a consequence in the next cycle.
`define BDA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define BDA_ASSERT_ALWAYS(label, clk, rst_n, expr)
`define BDA_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define BDA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> hw/rtl/bda_pkg.sv
// Shared types, widths and constants of the binary to decimal ASCII converter.
`timescale 1ns / 1ps
package bda_pkg;

    localparam int VALUE_W = 32;
    localparam int DIGIT_W = 4;
    localparam int CHAR_W  = 6;
    // Wide enough for nine times ten to the ninth and for ten to the tenth
    localparam int PROD_W  = 34;

    localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

    // Control that travels down the digit chain beside the remainder
    typedef struct packed {
        logic valid;
        logic drop;
    } t_stage_ctl;

    // Ten to the power n, evaluated at elaboration
    function automatic logic [63:0] pow10(input int n);
        logic [63:0] acc;
        acc = 64'd1;
        for (int i = 0; i < n; i++) begin
            acc = acc * 64'd10;
        end
        return acc;
    endfunction

endpackage

>>> hw/rtl/bda_cell.sv
// One digit cell: peels one decimal digit off the remainder and passes the rest on.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bda_cell #(
    parameter int MAX_DIGITS = 5,
    parameter int SLOT       = 0
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  bda_pkg::t_stage_ctl                     i_ctl,
    input  logic [bda_pkg::VALUE_W-1:0]             i_rem,
    input  logic [MAX_DIGITS*bda_pkg::DIGIT_W-1:0]  i_digits,
    output logic                                    o_ready,
    output bda_pkg::t_stage_ctl                     o_ctl,
    output logic [bda_pkg::VALUE_W-1:0]             o_rem,
    output logic [MAX_DIGITS*bda_pkg::DIGIT_W-1:0]  o_digits,
    input  logic                                    i_ready
);

    localparam int PW = bda_pkg::PROD_W;
    localparam int VW = bda_pkg::VALUE_W;
    localparam int DW = bda_pkg::DIGIT_W;
    localparam logic [PW-1:0] POW = PW'(bda_pkg::pow10(MAX_DIGITS - 1 - SLOT));

    bda_pkg::t_stage_ctl                 r_ctl;
    logic [VW-1:0]                       r_rem;
    logic [MAX_DIGITS*DW-1:0]            r_digits;
    logic [DW-1:0]                       w_digit;
    logic [PW-1:0]                       w_sub;
    logic [PW-1:0]                       w_rem_ext;
    logic [VW-1:0]                       n_rem;
    logic [MAX_DIGITS*DW-1:0]            n_digits;

    // Take a new word when empty or when the next cell takes ours
    assign o_ready   = !r_ctl.valid || i_ready;
    assign w_rem_ext = PW'(i_rem);

    // Compare against every multiple of the place value, keep the highest that fits
    always_comb begin
        w_digit = '0;
        w_sub   = '0;
        for (int m = 1; m < 10; m++) begin
            if (w_rem_ext >= PW'(m) * POW) begin
                w_digit = DW'(m);
                w_sub   = PW'(m) * POW;
            end
        end
        n_rem    = i_rem - w_sub[VW-1:0];
        n_digits = i_digits;
        n_digits[SLOT*DW +: DW] = w_digit;
    end

    // Hold valid state under stall, advance it otherwise
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (o_ready) begin
            r_ctl <= i_ctl;
        end
    end

    // Load payload with each accepted word
    always_ff @(posedge i_clk) begin
        if (o_ready && i_ctl.valid) begin
            r_rem    <= n_rem;
            r_digits <= n_digits;
        end
    end

    assign o_ctl    = r_ctl;
    assign o_rem    = r_rem;
    assign o_digits = r_digits;

    `BDA_ASSERT_IMPLIES(a_rem_below_place, i_clk, i_rst_n, r_ctl.valid && !r_ctl.drop, PW'(r_rem) < POW)
    `BDA_ASSERT_IMPLIES(a_digit_decimal, i_clk, i_rst_n, r_ctl.valid, r_digits[SLOT*DW +: DW] <= DW'(9))
    `BDA_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, r_ctl.valid && !i_ready, r_ctl.valid && $stable(r_digits))

endmodule

>>> hw/rtl/bda_ser.sv
// Output serializer: drops leading zeros and sends one ASCII digit per word.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bda_ser #(
    parameter int MAX_DIGITS = 5
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  bda_pkg::t_stage_ctl                     i_ctl,
    input  logic [MAX_DIGITS*bda_pkg::DIGIT_W-1:0]  i_digits,
    output logic                                    o_ready,
    output logic                                    o_tvalid,
    input  logic                                    i_tready,
    output logic [7:0]                              o_tdata,
    output logic                                    o_tlast
);

    localparam int DW    = bda_pkg::DIGIT_W;
    localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_DIGITS - 1);

    logic                     r_busy;
    logic                     n_busy;
    logic [IDX_W-1:0]         r_idx;
    logic [IDX_W-1:0]         n_idx;
    logic [MAX_DIGITS*DW-1:0] r_digits;
    logic [DW-1:0]            w_digit [MAX_DIGITS];
    logic [IDX_W-1:0]         w_start;
    logic                     w_load;
    logic                     w_done;

    // Split the digit word into slots, most significant first
    for (genvar g = 0; g < MAX_DIGITS; g++) begin : g_slot
        assign w_digit[g] = r_digits[g*DW +: DW];
    end

    // Find the first nonzero digit; an all-zero value keeps only the units digit
    always_comb begin
        w_start = LAST_IDX;
        for (int i = MAX_DIGITS - 1; i >= 0; i--) begin
            if (i_digits[i*DW +: DW] != '0) begin
                w_start = IDX_W'(i);
            end
        end
    end

    assign w_done  = r_busy && i_tready && (r_idx == LAST_IDX);
    assign o_ready = !r_busy || w_done;
    assign w_load  = i_ctl.valid && o_ready;

    // Advance through the digits, reload on the last one
    always_comb begin
        n_busy = r_busy;
        n_idx  = r_idx;
        if (r_busy && i_tready) begin
            if (r_idx == LAST_IDX) begin
                n_busy = 1'b0;
            end else begin
                n_idx = r_idx + IDX_W'(1);
            end
        end
        if (w_load && !i_ctl.drop) begin
            n_busy = 1'b1;
            n_idx  = w_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else begin
            r_busy <= n_busy;
            r_idx  <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load && !i_ctl.drop) begin
            r_digits <= i_digits;
        end
    end

    // Drive the output word from the held digits
    assign o_tvalid = r_busy;
    assign o_tdata  = {2'b00, bda_pkg::ASCII_ZERO + bda_pkg::CHAR_W'(w_digit[r_idx])};
    assign o_tlast  = (r_idx == LAST_IDX);

    `BDA_ASSERT_IMPLIES(a_out_decimal, i_clk, i_rst_n, r_busy, w_digit[r_idx] <= DW'(9))
    `BDA_ASSERT_NEXT(a_run_continues, i_clk, i_rst_n, r_busy && i_tready && !o_tlast, r_busy)
    `BDA_ASSERT_NEXT(a_lead_nonzero, i_clk, i_rst_n, w_load && !i_ctl.drop, r_busy && (w_digit[r_idx] != '0 || o_tlast))

endmodule

>>> hw/rtl/binary_to_decimal_ascii_core.sv
// An accepted value passes the registered digit cells, one per place, then the serializer.
// Throughput: one value per cycle enters the digit chain unless the serializer stalls it;
// one character per cycle leaves while o_tready is high, one per digit (1 to MAX_DIGITS).
// Values of 10^MAX_DIGITS or more pass the chain and are discarded without output.
// Synchronous active-low reset clears the valid and busy flags; no clearing pass.
`timescale 1ns / 1ps
module binary_to_decimal_ascii_core #(
    parameter int MAX_DIGITS = 5
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input words
    input  logic        i_tvalid,
    output logic        i_tready,
    input  logic [31:0] i_tdata,   // [31:0] value
    // Output words
    output logic        o_tvalid,
    input  logic        o_tready,
    output logic [7:0]  o_tdata,   // [5:0] digit_char, [7:6] zero
    output logic        o_tlast    // last
);

    localparam int DW = bda_pkg::DIGIT_W;
    localparam int VW = bda_pkg::VALUE_W;
    localparam logic [63:0] LIMIT = bda_pkg::pow10(MAX_DIGITS);

    bda_pkg::t_stage_ctl      w_ctl    [MAX_DIGITS+1];
    logic [VW-1:0]            w_rem    [MAX_DIGITS+1];
    logic [MAX_DIGITS*DW-1:0] w_digits [MAX_DIGITS+1];
    logic                     w_ready  [MAX_DIGITS+1];

    // Feed the chain; flag out-of-range values for discard
    assign w_ctl[0].valid = i_tvalid;
    assign w_ctl[0].drop  = (64'(i_tdata) >= LIMIT);
    assign w_rem[0]       = i_tdata;
    assign w_digits[0]    = '0;
    assign i_tready       = w_ready[0];

    // Chain of digit cells, most significant place first
    for (genvar g = 0; g < MAX_DIGITS; g++) begin : g_cell
        bda_cell #(
            .MAX_DIGITS (MAX_DIGITS),
            .SLOT       (g)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (w_ctl[g]),
            .i_rem    (w_rem[g]),
            .i_digits (w_digits[g]),
            .o_ready  (w_ready[g]),
            .o_ctl    (w_ctl[g+1]),
            .o_rem    (w_rem[g+1]),
            .o_digits (w_digits[g+1]),
            .i_ready  (w_ready[g+1])
        );
    end

    // Serialize the finished digits onto the output port
    bda_ser #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_ser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl[MAX_DIGITS]),
        .i_digits (w_digits[MAX_DIGITS]),
        .o_ready  (w_ready[MAX_DIGITS]),
        .o_tvalid (o_tvalid),
        .i_tready (o_tready),
        .o_tdata  (o_tdata),
        .o_tlast  (o_tlast)
    );

    // The final remainder is always zero for kept values
    logic w_unused_rem;
    assign w_unused_rem = ^w_rem[MAX_DIGITS];

endmodule

>>> verif/binary_to_decimal_ascii_checker.sv
// Checker that predicts and compares the decimal ASCII characters of each accepted value.
`timescale 1ns / 1ps
module binary_to_decimal_ascii_checker #(
    parameter int MAX_DIGITS = 5
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input words seen at the block
    input  logic        i_in_tvalid,
    input  logic        i_in_tready,
    input  logic [31:0] i_in_tdata,    // [31:0] value
    // Output words seen at the block
    input  logic        i_out_tvalid,
    input  logic        i_out_tready,
    input  logic [7:0]  i_out_tdata,   // [5:0] digit_char, [7:6] zero
    input  logic        i_out_tlast,   // last
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [bda_pkg::CHAR_W-1:0] digit_char;
        logic                       last;
    } t_digit_word;

    t_digit_word expected_chars[$];
    logic [63:0] print_limit;
    int          mismatch_total = 0;

    initial begin
        print_limit  = 64'd1;
        repeat (MAX_DIGITS) print_limit = print_limit * 64'd10;
    end

    // Queue the characters of one value, most significant digit first
    function automatic void queue_decimal_chars(input logic [bda_pkg::VALUE_W-1:0] value);
        logic [3:0]                  digits [10];
        logic [bda_pkg::VALUE_W-1:0] rest;
        t_digit_word                 word;
        int                          count;
        if ({32'd0, value} >= print_limit) return;
        rest  = value;
        count = 0;
        // zero still gives one digit
        do begin
            digits[count] = 4'(rest % 10);
            rest          = rest / 10;
            count++;
        end while (rest != 0);
        for (int k = count - 1; k >= 0; k--) begin
            word.digit_char = bda_pkg::ASCII_ZERO + digits[k];
            word.last       = (k == 0);
            expected_chars.push_back(word);
        end
    endfunction

    // Predict on each accepted value, compare each accepted character
    always @(posedge i_clk) begin
        t_digit_word want;
        if (!i_rst_n) begin
            expected_chars.delete();
        end else begin
            if (i_in_tvalid && i_in_tready) begin
                queue_decimal_chars(i_in_tdata);
            end
            if (i_out_tvalid && i_out_tready) begin
                if (expected_chars.size() == 0) begin
                    $error("unexpected word: digit_char %0d, last %0b",
                           i_out_tdata[bda_pkg::CHAR_W-1:0], i_out_tlast);
                    mismatch_total++;
                end else begin
                    want = expected_chars.pop_front();
                    if (i_out_tdata[bda_pkg::CHAR_W-1:0] !== want.digit_char) begin
                        $error("digit_char mismatch: expected %0d, actual %0d",
                               want.digit_char, i_out_tdata[bda_pkg::CHAR_W-1:0]);
                        mismatch_total++;
                    end
                    if (i_out_tlast !== want.last) begin
                        $error("last mismatch: expected %0b, actual %0b",
                               want.last, i_out_tlast);
                        mismatch_total++;
                    end
                    if (i_out_tdata[7:bda_pkg::CHAR_W] !== '0) begin
                        $error("pad mismatch: expected 0, actual %0d",
                               i_out_tdata[7:bda_pkg::CHAR_W]);
                        mismatch_total++;
                    end
                end
            end
        end
        o_fail_count <= mismatch_total;
        o_pending    <= expected_chars.size();
    end

endmodule

>>> verif/binary_to_decimal_ascii_core_test.sv
// Top of the converter test: clock, reset, value stimulus, ready stalls and verdict.
`timescale 1ns / 1ps
module binary_to_decimal_ascii_core_test;

    localparam int MAX_DIGITS   = 5;
    localparam int RANDOM_ITEMS = 500;
    localparam int PHASES       = 4;
    localparam int IDLE_LIMIT   = 2000;

    logic                        i_clk;
    logic                        i_rst_n    = 1'b0;
    logic                        in_tvalid  = 1'b0;
    logic [bda_pkg::VALUE_W-1:0] in_tdata   = '0;
    logic                        out_tready = 1'b0;
    logic                        in_tready;
    logic                        out_tvalid;
    logic [7:0]                  out_tdata;
    logic                        out_tlast;

    int fail_count;
    int pending;
    int gap_pct     = 0;
    int stall_pct   = 0;
    int idle_cycles = 0;

    // Corner values: digit-count boundaries, range edge, all-ones and alternating bits
    logic [bda_pkg::VALUE_W-1:0] corner_values [22] = '{
        32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd999, 32'd1000,
        32'd9999, 32'd10000, 32'd99999, 32'd100000, 32'd100001, 32'hFFFFFFFF,
        32'h80000000, 32'd12345, 32'd67890, 32'd90909, 32'd10001, 32'd50000,
        32'hAAAAAAAA, 32'h55555555
    };

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    binary_to_decimal_ascii_core #(
        .MAX_DIGITS (MAX_DIGITS)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tvalid (in_tvalid),
        .i_tready (in_tready),
        .i_tdata  (in_tdata),
        .o_tvalid (out_tvalid),
        .o_tready (out_tready),
        .o_tdata  (out_tdata),
        .o_tlast  (out_tlast)
    );

    binary_to_decimal_ascii_checker #(
        .MAX_DIGITS (MAX_DIGITS)
    ) checker_0 (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_tvalid  (in_tvalid),
        .i_in_tready  (in_tready),
        .i_in_tdata   (in_tdata),
        .i_out_tvalid (out_tvalid),
        .i_out_tready (out_tready),
        .i_out_tdata  (out_tdata),
        .i_out_tlast  (out_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Stall the character stream at random
    always @(negedge i_clk) begin
        out_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Abort when no word moves on either side for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic [63:0] decade(input int n);
        logic [63:0] acc;
        acc = 64'd1;
        repeat (n) acc = acc * 64'd10;
        return acc;
    endfunction

    // Mostly printable values spread over every digit count, the rest out of range
    function automatic logic [bda_pkg::VALUE_W-1:0] random_value();
        int          roll;
        int          digits;
        logic [63:0] lo;
        logic [63:0] hi;
        roll = $urandom_range(99);
        if (roll < 8) begin
            return $urandom_range(32'hFFFFFFFF, 32'(decade(MAX_DIGITS)));
        end else if (roll < 12) begin
            return 32'(decade(MAX_DIGITS) + 64'($urandom_range(9)));
        end
        digits = $urandom_range(MAX_DIGITS, 1);
        lo     = (digits == 1) ? 64'd0 : decade(digits - 1);
        hi     = decade(digits) - 64'd1;
        return $urandom_range(32'(hi), 32'(lo));
    endfunction

    // Present one value at a falling edge and hold it until accepted
    task automatic send_value(input logic [bda_pkg::VALUE_W-1:0] value);
        while ($urandom_range(99) < gap_pct) begin
            in_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        in_tvalid <= 1'b1;
        in_tdata  <= value;
        do @(posedge i_clk); while (!in_tready);
        @(negedge i_clk);
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (corner_values[i]) send_value(corner_values[i]);

        // Phases: no idling, sender gaps, receiver stalls, both
        for (int phase = 0; phase < PHASES; phase++) begin
            gap_pct   = (phase == 1) ? 73 : (phase == 3) ? 34 : 0;
            stall_pct = (phase == 2) ? 73 : (phase == 3) ? 34 : 0;
            for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
                send_value(random_value());
            end
        end
        in_tvalid <= 1'b0;

        // Drain, then give any trailing word time to show up
        while (pending != 0) @(posedge i_clk);
        repeat (4 * (MAX_DIGITS + 1)) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
